>>> hw/rtl/lfr_pkg.sv
// Shared types and codes for the frame receiver.
// Holds the input word and result structs and the result kind codes; no dependencies.
package lfr_pkg;

    // Result kind codes
    localparam logic [1:0] KIND_STORED      = 2'd0;
    localparam logic [1:0] KIND_DONE        = 2'd1;
    localparam logic [1:0] KIND_INTERRUPTED = 2'd2;
    localparam logic [1:0] KIND_TOO_LONG    = 2'd3;

    // Largest number of results one input word can cause
    localparam int unsigned MAX_RESULTS = 3;

    // One received word
    typedef struct packed {
        logic [31:0] word_data;
        logic        start_flag;
        logic        end_flag;
        logic [1:0]  remainder;
    } t_in;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  word_index;
        logic [31:0] stored_word;
        logic [12:0] frame_bytes;
        logic        last;
    } t_out;

    // All results caused by one word, in delivery order
    typedef struct packed {
        logic [1:0]                   count;
        t_out [MAX_RESULTS-1:0]       ent;
    } t_bundle;

endpackage

>>> hw/rtl/lfr_frame_ctl.sv
// Frame tracking for the frame receiver: word counter, capacity register and
// the per-word result bundle. Depends on lfr_pkg.
module lfr_frame_ctl #(
    parameter int MAX_WORDS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [10:0]      i_cfg_wr_data,
    input  logic             i_fire,
    input  lfr_pkg::t_in     i_item,
    output lfr_pkg::t_bundle o_bundle
);
    import lfr_pkg::*;

    logic [10:0] r_capacity;
    logic [10:0] r_count;
    logic [10:0] n_count;
    logic [10:0] cap;

    // Effective capacity: smaller of the register and MAX_WORDS
    always_comb begin
        if (32'(r_capacity) > 32'(MAX_WORDS)) begin
            cap = 11'(MAX_WORDS);
        end else begin
            cap = r_capacity;
        end
    end

    // Results of one word and the next counter value
    always_comb begin
        t_out        res;
        logic [1:0]  n;
        logic [10:0] base;
        logic [10:0] next_cnt;
        logic [12:0] bytes;
        logic        open;
        logic        proceed;

        o_bundle = '0;
        n        = 2'd0;
        res      = '0;
        open     = (r_count != 11'd0);
        proceed  = i_item.start_flag || open;
        base     = r_count;
        next_cnt = r_count + 11'd1;
        bytes    = '0;
        n_count  = r_count;

        // start inside an open frame: report and restart with this word
        if (i_item.start_flag && open) begin
            res.kind          = KIND_INTERRUPTED;
            o_bundle.ent[n]   = res;
            n                 = n + 2'd1;
            base              = 11'd0;
            next_cnt          = 11'd1;
            n_count           = 11'd0;
        end

        if (proceed) begin
            if (base < cap) begin
                res             = '0;
                res.kind        = KIND_STORED;
                res.word_index  = base[9:0];
                res.stored_word = i_item.word_data;
                o_bundle.ent[n] = res;
                n               = n + 2'd1;
                n_count         = next_cnt;
                if (i_item.end_flag) begin
                    bytes           = {next_cnt, 2'b00} - 13'd3 + {11'd0, i_item.remainder};
                    res             = '0;
                    res.kind        = KIND_DONE;
                    res.frame_bytes = bytes;
                    o_bundle.ent[n] = res;
                    n               = n + 2'd1;
                    n_count         = 11'd0;
                end
            end else begin
                res             = '0;
                res.kind        = KIND_TOO_LONG;
                o_bundle.ent[n] = res;
                n               = n + 2'd1;
                n_count         = 11'd0;
            end
        end

        if (n != 2'd0) begin
            o_bundle.ent[n - 2'd1].last = 1'b1;
        end
        o_bundle.count = n;
    end

    // Counter and capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= 11'd0;
            r_capacity <= 11'd1024;
        end else begin
            if (i_fire) begin
                r_count <= n_count;
            end
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
        end
    end

endmodule

>>> hw/rtl/locallink_frame_receiver.sv
// Throughput: one word per cycle while each word yields at most one result and
// i_stall is low; a word yielding several results holds the result register
// until each of its results is taken.
// Words go input register -> frame logic -> result bundle register.
// Reset (synchronous, active low) empties both registers, clears the word count
// and sets the capacity register to 1024.
module locallink_frame_receiver #(
    parameter int MAX_WORDS = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  lfr_pkg::t_in  i_item,
    output logic          o_valid,
    input  logic          i_stall,
    output lfr_pkg::t_out o_item,
    input  logic          i_cfg_wr_en,
    input  logic [10:0]   i_cfg_wr_data
);
    import lfr_pkg::*;

    logic        r_in_valid;
    t_in         r_in;
    logic [1:0]  r_cnt;
    logic [1:0]  r_pos;
    t_out [MAX_RESULTS-1:0] r_ent;
    t_bundle     bundle;
    logic        take;
    logic        take_last;
    logic        bundle_free;
    logic        fire;
    logic        in_accept;

    // Output side handshake
    assign o_valid     = (r_cnt != 2'd0);
    assign o_item      = r_ent[r_pos];
    assign take        = o_valid && !i_stall;
    assign take_last   = take && (r_pos == r_cnt - 2'd1);
    assign bundle_free = (r_cnt == 2'd0) || take_last;

    // Word moves from input register into frame logic when the bundle frees up
    assign fire      = r_in_valid && bundle_free;
    assign o_stall   = r_in_valid && !bundle_free;
    assign in_accept = i_valid && !o_stall;

    lfr_frame_ctl #(
        .MAX_WORDS(MAX_WORDS)
    ) u_frame_ctl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_fire       (fire),
        .i_item       (r_in),
        .o_bundle     (bundle)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_item;
        end
    end

    // Result bundle register, drained one result per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_pos <= 2'd0;
        end else if (fire) begin
            r_cnt <= bundle.count;
            r_pos <= 2'd0;
        end else if (take_last) begin
            r_cnt <= 2'd0;
            r_pos <= 2'd0;
        end else if (take) begin
            r_pos <= r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_ent <= bundle.ent;
        end
    end

    // Checks
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_pos < r_cnt))
        else $error("result position beyond bundle count");

    a_last_marks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.last == (r_pos == r_cnt - 2'd1)))
        else $error("last flag does not match final result of word");

    a_interrupt_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.kind == KIND_INTERRUPTED) |-> !o_item.last)
        else $error("interrupted report must be followed by the word's own result");

    a_non_stored_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.kind != KIND_STORED) |->
            (o_item.word_index == 10'd0 && o_item.stored_word == 32'd0))
        else $error("index or data set on a non-stored result");

    a_no_fire_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && o_valid && i_stall) |=> $stable(r_ent))
        else $error("bundle overwritten while a result is stalled");

endmodule
